// ===== hw/rtl/pglm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pglm_pkg;

  localparam int NUM_INPUTS_DEF = 4;
  localparam int NUM_BASIS_DEF  = 8;

  // field widths
  localparam int IDX_W   = 5;
  localparam int VAL_W   = 16;
  localparam int SPK_W   = 8;
  localparam int CUR_W   = 40;
  localparam int LL_W    = 48;
  localparam int TAB_DEPTH = 32;

  // register indexes
  localparam logic REG_BIAS_CURRENT = 1'b0;
  localparam logic REG_BIN_WIDTH    = 1'b1;

  localparam logic [15:0] BIAS_RESET = 16'd4096;
  localparam logic [15:0] BW_RESET   = 16'd6554;

  // operation codes on the input channel
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_FEATURE = 1'b1;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic signed [16:0] LN2_Q16 = 17'sd45426;

  typedef logic [30:0] exp_tab_t [16];

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_MUL,
    CMD_ACC,
    CMD_CUR,
    CMD_Y,
    CMD_EXP,
    CMD_EXP_END,
    CMD_LN_NORM,
    CMD_LN_SQ,
    CMD_LN_FIN,
    CMD_RATE,
    CMD_TERM_MUL,
    CMD_TERM_ACC,
    CMD_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic bin_end;
    logic set_end;
    logic cnt_last;
    logic norm_done;
    logic out_free;
  } dp_status_t;

  // floor integer square root, elaboration only
  function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = v_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // factors 2^(-2^-(k+1)) in Q30, entry k used for fraction bit 15-k
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      c = isqrt_c(c << 30);
      t[k] = c[30:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

// ===== hw/rtl/pglm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pglm_dp #(
  parameter int NUM_INPUTS = pglm_pkg::NUM_INPUTS_DEF,
  parameter int NUM_BASIS  = pglm_pkg::NUM_BASIS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pglm_pkg::dp_cmd_t          cmd,
  output pglm_pkg::dp_status_t            status,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [15:0]                cfg_data,
  input  wire logic                       in_op,
  input  wire logic [pglm_pkg::IDX_W-1:0] in_idx,
  input  wire logic [pglm_pkg::VAL_W-1:0] in_val,
  input  wire logic [pglm_pkg::SPK_W-1:0] in_spk,
  input  wire logic                       in_bin_end,
  input  wire logic                       in_set_end,
  output logic [pglm_pkg::LL_W-1:0]       out_ll,
  output logic                            out_sat,
  output logic                            out_valid,
  input  wire logic                       out_ready
);
  import pglm_pkg::*;

  localparam int NUM_ELEM = NUM_INPUTS * NUM_BASIS;

  logic signed [VAL_W-1:0] weight_mem [TAB_DEPTH];

  logic signed [15:0] bias;
  logic [15:0]        bw;

  logic [IDX_W-1:0]        idx_q;
  logic signed [VAL_W-1:0] val_q;
  logic signed [VAL_W-1:0] w_q;
  logic [SPK_W-1:0]        spk_q;
  logic                    bin_q;
  logic                    set_q;
  logic signed [31:0]      prod;

  logic signed [CUR_W-1:0] cur_sum;
  logic signed [LL_W-1:0]  ll_sum;
  logic                    sat;

  logic signed [32:0] x;
  logic [32:0]        a;
  logic [17:0]        n;
  logic [15:0]        f;
  logic [30:0]        r;
  logic [3:0]         cnt;

  logic [33:0]        m;
  logic signed [6:0]  p;
  logic [4:0]         fb;
  logic [15:0]        f2;
  logic signed [23:0] ln_res;
  logic [33:0]        rate;
  logic [49:0]        p1;
  logic signed [32:0] p2;

  // combinational terms
  logic               in_range_in;
  logic               in_range_q;
  logic signed [40:0] acc_sum;
  logic signed [40:0] cur_full;
  logic [49:0]        ymul;
  logic [61:0]        rc;
  logic [30:0]        e_val;
  logic [61:0]        sq;
  logic [31:0]        t;
  logic signed [6:0]  pd;
  logic signed [22:0] l2;
  logic signed [39:0] lnp;
  logic [31:0]        xpos;
  logic [33:0]        rate_c;
  logic signed [35:0] term;
  logic signed [48:0] ll_new;

  assign in_range_in = 32'(in_idx) < 32'(NUM_ELEM);
  assign in_range_q  = 32'(idx_q) < 32'(NUM_ELEM);

  assign acc_sum  = {cur_sum[CUR_W-1], cur_sum} + {{9{prod[31]}}, prod};
  assign cur_full = {cur_sum[CUR_W-1], cur_sum} + {{13{bias[15]}}, bias, 12'b0};
  assign ymul     = 50'(a) * 50'(LOG2E_Q16);
  assign rc       = 62'(r) * 62'(EXP_TAB[cnt]);
  assign e_val    = (n >= 18'd31) ? 31'd0 : (r >> n[4:0]);
  assign sq       = 62'(m[30:0]) * 62'(m[30:0]);
  assign t        = sq[61:30];
  assign pd       = p - $signed({2'b00, fb});
  assign l2       = $signed({pd, f2});
  assign lnp      = 40'(l2) * 40'(LN2_Q16);
  assign xpos     = x[32] ? 32'd0 : x[31:0];
  assign rate_c   = {2'b00, xpos} + {10'd0, ln_res[23:0]};
  assign term     = $signed({{3{p2[32]}}, p2}) - $signed({2'b00, p1[49:16]});
  assign ll_new   = {ll_sum[LL_W-1], ll_sum} + {{13{term[35]}}, term};

  assign status.bin_end   = bin_q;
  assign status.set_end   = set_q;
  assign status.cnt_last  = (cnt == 4'd15);
  assign status.norm_done = (m[33:31] == 3'd0) && m[30];
  assign status.out_free  = !out_valid || out_ready;

  // weight store, registered read
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_CAPTURE) begin
      if (in_op == OP_LOAD && in_range_in) weight_mem[in_idx] <= $signed(in_val);
      w_q <= weight_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias      <= $signed(BIAS_RESET);
      bw        <= BW_RESET;
      cur_sum   <= '0;
      ll_sum    <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BIAS_CURRENT: bias <= $signed(cfg_data);
          REG_BIN_WIDTH:    bw   <= cfg_data;
        endcase
      end
      if (cmd.op == CMD_EMIT) out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;

      unique case (cmd.op)
        CMD_ACC: begin
          if (in_range_q) begin
            if (acc_sum[40] != acc_sum[39]) begin
              cur_sum <= acc_sum[40] ? {1'b1, {(CUR_W-1){1'b0}}} : {1'b0, {(CUR_W-1){1'b1}}};
              sat     <= 1'b1;
            end else begin
              cur_sum <= acc_sum[39:0];
            end
          end
        end
        CMD_CUR:  cur_sum <= '0;
        CMD_RATE: if (rate_c == '0) sat <= 1'b1;
        CMD_TERM_ACC: begin
          if (ll_new[48] != ll_new[47]) begin
            ll_sum <= ll_new[48] ? {1'b1, {(LL_W-1){1'b0}}} : {1'b0, {(LL_W-1){1'b1}}};
            sat    <= 1'b1;
          end else begin
            ll_sum <= ll_new[47:0];
          end
        end
        CMD_EMIT: begin
          ll_sum <= '0;
          sat    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_CAPTURE: begin
        idx_q <= in_idx;
        val_q <= $signed(in_val);
        spk_q <= in_spk;
        bin_q <= in_bin_end;
        set_q <= in_set_end;
      end
      CMD_MUL: prod <= 32'(w_q) * 32'(val_q);
      CMD_CUR: begin
        x <= cur_full[40:8];
        a <= cur_full[40] ? 33'(-cur_full[40:8]) : cur_full[40:8];
      end
      CMD_Y: begin
        n   <= ymul[49:32];
        f   <= ymul[31:16];
        r   <= 31'd1 << 30;
        cnt <= '0;
      end
      CMD_EXP: begin
        if (f[4'd15 - cnt]) r <= rc[60:30];
        cnt <= cnt + 4'd1;
      end
      CMD_EXP_END: begin
        m   <= (34'd1 << 30) + 34'(e_val);
        p   <= 7'sd30;
        fb  <= 5'd30;
        cnt <= '0;
        f2  <= '0;
      end
      CMD_LN_NORM: begin
        if (m[33:31] != 3'd0) begin
          m <= m >> 1;
          p <= p + 7'sd1;
        end else if (!m[30]) begin
          m <= m << 1;
          p <= p - 7'sd1;
        end
      end
      CMD_LN_SQ: begin
        if (t[31]) m <= {3'b000, t[31:1]};
        else       m <= {2'b00, t};
        f2  <= {f2[14:0], t[31]};
        cnt <= cnt + 4'd1;
      end
      CMD_LN_FIN: ln_res <= lnp[39:16];
      CMD_RATE: begin
        rate <= rate_c;
        m    <= (rate_c == '0) ? 34'd1 : rate_c;
        p    <= 7'sd30;
        fb   <= 5'd16;
        cnt  <= '0;
        f2   <= '0;
      end
      CMD_TERM_MUL: begin
        p1 <= 50'(bw) * 50'(rate);
        p2 <= 33'($signed({1'b0, spk_q})) * 33'(ln_res);
      end
      CMD_EMIT: begin
        out_ll  <= ll_sum;
        out_sat <= sat;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pglm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pglm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_op,
  output logic                      in_ready,
  output pglm_pkg::dp_cmd_t         cmd,
  input  wire pglm_pkg::dp_status_t status
);
  import pglm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_CUR, S_Y, S_EXP, S_EXP_END, S_LN_NORM,
    S_LN_SQ, S_LN_FIN, S_RATE, S_TERM_MUL, S_TERM_ACC, S_EMIT
  } state_t;

  state_t state;
  logic   ln_second;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? CMD_CAPTURE : CMD_NONE;
      S_MUL:      cmd.op = CMD_MUL;
      S_ACC:      cmd.op = CMD_ACC;
      S_CUR:      cmd.op = CMD_CUR;
      S_Y:        cmd.op = CMD_Y;
      S_EXP:      cmd.op = CMD_EXP;
      S_EXP_END:  cmd.op = CMD_EXP_END;
      S_LN_NORM:  cmd.op = CMD_LN_NORM;
      S_LN_SQ:    cmd.op = CMD_LN_SQ;
      S_LN_FIN:   cmd.op = CMD_LN_FIN;
      S_RATE:     cmd.op = CMD_RATE;
      S_TERM_MUL: cmd.op = CMD_TERM_MUL;
      S_TERM_ACC: cmd.op = CMD_TERM_ACC;
      S_EMIT:     cmd.op = status.out_free ? CMD_EMIT : CMD_NONE;
      default:    cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ln_second <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:     if (in_valid && in_op == OP_FEATURE) state <= S_MUL;
        S_MUL:      state <= S_ACC;
        S_ACC:      state <= status.bin_end ? S_CUR : S_IDLE;
        S_CUR:      state <= S_Y;
        S_Y:        state <= S_EXP;
        S_EXP:      if (status.cnt_last) state <= S_EXP_END;
        S_EXP_END: begin
          state     <= S_LN_NORM;
          ln_second <= 1'b0;
        end
        S_LN_NORM:  if (status.norm_done) state <= S_LN_SQ;
        S_LN_SQ:    if (status.cnt_last) state <= S_LN_FIN;
        S_LN_FIN:   state <= ln_second ? S_TERM_MUL : S_RATE;
        S_RATE: begin
          state     <= S_LN_NORM;
          ln_second <= 1'b1;
        end
        S_TERM_MUL: state <= S_TERM_ACC;
        S_TERM_ACC: state <= status.set_end ? S_EMIT : S_IDLE;
        S_EMIT:     if (status.out_free) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/poisson_glm_log_likelihood_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// poisson glm log-likelihood core, softplus link
// input channel s_axis: weight loads (tuser[0]=0) write the weight store and
//   leave the input ready; feature elements (tuser[0]=1) run a store read, a
//   16x16 multiply and a saturating accumulate into the 40-bit current
// tlast on a feature marks bin end: bias is added, softplus and log are run
//   on a shared iterative unit: 16 exp steps, two logs of 16 squaring steps
//   each plus a normalize walk of one bit per cycle; the walk is longest
//   when the rate is tiny
// tuser[1] with tlast ends the set: the 48-bit Q32.16 total leaves on m_axis
//   with the saturation flag in tuser[0]
// the output register lets the next item be taken while a result waits; a
//   second set end waits until the first result has been taken
// reset clears sums, flags and config registers to their defaults; the weight store
//   is not cleared and must be loaded before use
// config: cfg_we writes cfg_data into register cfg_index (0 bias, 1 dt)
module poisson_glm_log_likelihood_core #(
  parameter int NUM_INPUTS = pglm_pkg::NUM_INPUTS_DEF,
  parameter int NUM_BASIS  = pglm_pkg::NUM_BASIS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // element_index, value, spike_count
  input  wire logic        s_axis_tlast,  // last_of_bin
  input  wire logic [1:0]  s_axis_tuser,  // operation, last_of_set
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // summed total, Q32.16
  output logic [0:0]       m_axis_tuser,  // saturated
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import pglm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller sequences the datapath, one command per cycle
  pglm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  pglm_dp #(
    .NUM_INPUTS (NUM_INPUTS),
    .NUM_BASIS  (NUM_BASIS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index[0]),
    .cfg_data   (cfg_data),
    .in_op      (s_axis_tuser[0]),
    .in_idx     (s_axis_tdata[4:0]),
    .in_val     (s_axis_tdata[20:5]),
    .in_spk     (s_axis_tdata[28:21]),
    .in_bin_end (s_axis_tlast),
    .in_set_end (s_axis_tuser[1]),
    .out_ll     (m_axis_tdata),
    .out_sat    (m_axis_tuser[0]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/pglm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pglm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  import pglm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  // after a weight load the input is ready again in the next cycle
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_LOAD |=> s_axis_tready)
    else $error("busy after weight load");

  // a feature keeps the multiply-accumulate busy
  a_feature_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_FEATURE |=> !s_axis_tready)
    else $error("ready during feature accumulate");

endmodule

bind poisson_glm_log_likelihood_core pglm_checker u_pglm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
